>>> design/upc_pkg.sv
// upc_pkg: shared types, constants and helper functions for the uri percent codec
// used by upc_front, upc_fifo, upc_back and uri_percent_codec_unit
// no dependencies
package upc_pkg;

	// character constants
	localparam logic [7:0] PCT_CHAR       = 8'h25;
	localparam logic [7:0] DIGIT_BASE     = 8'h30;
	localparam logic [7:0] HEX_ALPHA_BASE = 8'h57; // 'a' - 10

	// configuration register indexes
	localparam logic CFG_DIRECTION = 1'b0;
	localparam logic CFG_COMPONENT = 1'b1;

	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	localparam logic [1:0] COMPONENT_RESET = 2'd1;

	// queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// class bits for bytes 0x00..0x7f; bytes 0x80..0xff have none
	localparam logic [3:0] CLASS_TABLE [128] = '{
		4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0, 4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,
		4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0, 4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,4'h0,
		4'h0,4'hf,4'h0,4'h0,4'hf,4'h0,4'hf,4'hf, 4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'he,
		4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf, 4'hf,4'hf,4'hf,4'hf,4'h0,4'hf,4'h0,4'hc,
		4'he,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf, 4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,
		4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf, 4'hf,4'hf,4'hf,4'h0,4'hf,4'h0,4'h0,4'hf,
		4'h0,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf, 4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,
		4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf,4'hf, 4'hf,4'hf,4'hf,4'h0,4'h0,4'h0,4'hf,4'h0
	};

	// decode hold state
	typedef enum logic [1:0] {
		HELD_NONE,
		HELD_PCT,
		HELD_DIGIT
	} held_t;

	// channel payloads
	typedef struct packed {
		logic [7:0] in_char;
		logic       in_last;
	} upc_in_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       out_last;
	} upc_out_t;

	// one classified item: up to three output bytes, sent from index 0 up
	typedef struct packed {
		logic [2:0][7:0] bytes;
		logic [1:0]      count;
		logic            last;
	} upc_job_t;

	// lower-case hex character of a nibble
	function automatic logic [7:0] hex_char(input logic [3:0] v);
		logic [7:0] w;
		w = {4'd0, v};
		return (v < 4'd10) ? 8'(w + DIGIT_BASE) : 8'(w + HEX_ALPHA_BASE);
	endfunction

	// {is hex digit, value} of a character, either case
	function automatic logic [4:0] hex_value(input logic [7:0] ch);
		logic [7:0] d;
		d = 8'd0;
		if (ch >= 8'h61 && ch <= 8'h66) begin
			d = 8'(ch - 8'h57);
			return {1'b1, d[3:0]};
		end else if (ch >= 8'h41 && ch <= 8'h46) begin
			d = 8'(ch - 8'h37);
			return {1'b1, d[3:0]};
		end else if (ch >= 8'h30 && ch <= 8'h39) begin
			d = 8'(ch - 8'h30);
			return {1'b1, d[3:0]};
		end
		return 5'd0;
	endfunction

endpackage

>>> design/upc_front.sv
// upc_front: accepts input items, holds configuration and decode state,
// and turns each item into a job of up to three output bytes
// depends on upc_pkg
module upc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  upc_pkg::upc_in_t  in_data,
	output logic              push,
	output upc_pkg::upc_job_t push_job,
	input  logic              push_ready
);
	import upc_pkg::*;

	logic       direction_q;
	logic [1:0] component_q;
	held_t      held_q, held_d;
	logic [7:0] digit_q, digit_d;

	logic [7:0] ch;
	logic       last;
	logic       accept;
	logic [4:0] lo_hex;
	logic [4:0] hi_hex;
	logic       ch_pct;
	upc_job_t   job;

	assign ch       = in_data.in_char;
	assign last     = in_data.in_last;
	assign in_ready = push_ready;
	assign accept   = in_valid && in_ready;
	assign lo_hex   = hex_value(ch);
	assign hi_hex   = hex_value(digit_q);
	assign ch_pct   = (ch == PCT_CHAR) && !last;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
			component_q <= COMPONENT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIRECTION: direction_q <= cfg_data[0];
				CFG_COMPONENT: component_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// decode hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= HELD_NONE;
			digit_q <= 8'd0;
		end else if (cfg_we && cfg_index == CFG_DIRECTION) begin
			held_q  <= HELD_NONE;
			digit_q <= 8'd0;
		end else if (accept) begin
			held_q  <= held_d;
			digit_q <= digit_d;
		end
	end

	// classify the item and build its job
	always_comb begin
		held_d     = held_q;
		digit_d    = digit_q;
		job.bytes  = '0;
		job.count  = 2'd0;
		job.last   = last;
		if (direction_q == DIR_ENCODE) begin
			if (!ch[7] && CLASS_TABLE[ch[6:0]][component_q]) begin
				job.bytes[0] = ch;
				job.count    = 2'd1;
			end else begin
				job.bytes[0] = PCT_CHAR;
				job.bytes[1] = hex_char(ch[7:4]);
				job.bytes[2] = hex_char(ch[3:0]);
				job.count    = 2'd3;
			end
		end else begin
			unique case (held_q)
				HELD_NONE: begin
					if (ch_pct) begin
						held_d = HELD_PCT;
					end else begin
						job.bytes[0] = ch;
						job.count    = 2'd1;
					end
				end
				HELD_PCT: begin
					job.bytes[0] = PCT_CHAR;
					if (lo_hex[4] && !last) begin
						held_d    = HELD_DIGIT;
						digit_d   = ch;
						job.count = 2'd0;
					end else if (ch_pct) begin
						held_d    = HELD_PCT;
						job.count = 2'd1;
					end else begin
						held_d       = HELD_NONE;
						job.bytes[1] = ch;
						job.count    = 2'd2;
					end
				end
				HELD_DIGIT: begin
					digit_d = 8'd0;
					if (lo_hex[4] && hi_hex[4]) begin
						held_d       = HELD_NONE;
						job.bytes[0] = {hi_hex[3:0], lo_hex[3:0]};
						job.count    = 2'd1;
					end else begin
						job.bytes[0] = PCT_CHAR;
						job.bytes[1] = digit_q;
						if (ch_pct) begin
							held_d    = HELD_PCT;
							job.count = 2'd2;
						end else begin
							held_d       = HELD_NONE;
							job.bytes[2] = ch;
							job.count    = 2'd3;
						end
					end
				end
				default: begin
					held_d = HELD_NONE;
				end
			endcase
		end
		// nothing stays pending past the last byte
		if (last) begin
			held_d  = HELD_NONE;
			digit_d = 8'd0;
		end
	end

	// items that emit nothing only update state
	assign push     = accept && (job.count != 2'd0);
	assign push_job = job;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last && !cfg_we) |=> (held_q == HELD_NONE))
		else $error("hold state survived a last item");
	a_digit_is_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(held_q == HELD_DIGIT) |-> hi_hex[4])
		else $error("held digit is not a hex character");
	a_encode_holds_nothing: assert property (@(posedge clk) disable iff (!arst_n)
		(direction_q == DIR_ENCODE) |-> (held_q == HELD_NONE))
		else $error("hold state set while encoding");

endmodule

>>> design/upc_fifo.sv
// upc_fifo: short job queue between the front and back parts
// depends on upc_pkg
module upc_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  upc_pkg::upc_job_t push_job,
	output logic              push_ready,
	input  logic              pop,
	output upc_pkg::upc_job_t pop_job,
	output logic              pop_valid
);
	import upc_pkg::*;

	upc_job_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push && push_ready) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (pop && pop_valid) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
					QPTR_W'(rd_ptr_q + 1'b1);
			end
			unique case ({push && push_ready, pop && pop_valid})
				2'b10:   count_q <= QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue fill count beyond depth");
	a_no_jobless_entry: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> (pop_job.count != 2'd0))
		else $error("queue holds a job with no bytes");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
		else $error("empty queue with mismatched pointers");

endmodule

>>> design/upc_back.sv
// upc_back: takes jobs from the queue and sends their bytes, one per cycle while
// out_ready is high, from the held job register
// depends on upc_pkg
module upc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  upc_pkg::upc_job_t pop_job,
	input  logic              pop_valid,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output upc_pkg::upc_out_t out_data
);
	import upc_pkg::*;

	upc_job_t   job_q;
	logic [1:0] idx_q;
	logic       busy_q;
	logic       at_end;
	logic       load;

	assign at_end = (idx_q == 2'(job_q.count - 2'd1));
	assign load   = !busy_q || (out_ready && at_end);
	assign pop    = load && pop_valid;

	// current job and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (load) begin
			busy_q <= pop_valid;
			idx_q  <= 2'd0;
		end else if (out_ready) begin
			idx_q  <= 2'(idx_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
	end

	assign out_valid         = busy_q;
	assign out_data.out_char = job_q.bytes[idx_q];
	assign out_data.out_last = job_q.last && at_end;

	a_idx_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (idx_q < job_q.count))
		else $error("byte index past end of job");
	a_no_lost_job: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && !out_ready) |-> !pop)
		else $error("job taken while output stalled");
	a_step_after_send: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && out_ready && !at_end) |=> (busy_q && idx_q == 2'($past(idx_q) + 2'd1)))
		else $error("byte index did not advance");

endmodule

>>> design/uri_percent_codec_unit.sv
// uri_percent_codec_unit: top level of the streaming uri percent encoder/decoder
// depends on upc_pkg, upc_front, upc_fifo, upc_back
//
// usage
// - in channel: one byte of a uri component per item, in_last on its final byte
// - out channel: converted bytes, out_last on the final byte of a string
// - config port: cfg_index 0 = direction (0 encode, 1 decode), 1 = component
//   (0 userinfo, 1 path, 2 query, 3 fragment); write only while idle
// - encode: a byte the class table allows passes, others become '%' and two
//   lower-case hex digits (1 or 3 output bytes per item)
// - decode: '%' and one hex digit are held; '%XY' becomes one byte, a broken
//   escape is passed through literally (0 to 3 output bytes per item)
// - an accepted item's job goes through the queue into the back job register
// - the back serializer sends one byte per cycle while out_ready is high and
//   goes straight on to the next queued job after the last byte of a job
// - the front keeps taking items into a two-job queue while the out side stalls;
//   in_ready drops only when that queue is full
// - reset: direction encode, component path, nothing held, queue empty
module uri_percent_codec_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [1:0]        cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  upc_pkg::upc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output upc_pkg::upc_out_t out_data
);
	import upc_pkg::*;

	logic     push;
	upc_job_t push_job;
	logic     push_ready;
	logic     pop;
	upc_job_t pop_job;
	logic     pop_valid;

	// classify items
	upc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready)
	);

	// job queue
	upc_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid)
	);

	// send bytes
	upc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_job    (pop_job),
		.pop_valid  (pop_valid),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

>>> verif/tb_top.sv
// tb_top: self-checking testbench for uri_percent_codec_unit, the streaming uri percent codec
// depends on upc_pkg and the design files; holds its own predictor in a small scoreboard class
// directed escapes and malformed sequences first, then randomized strings under several settings
module tb_top;
	import upc_pkg::*;

	// component selector codes
	localparam logic [1:0] COMP_USERINFO = 2'd0;
	localparam logic [1:0] COMP_PATH     = 2'd1;
	localparam logic [1:0] COMP_QUERY    = 2'd2;
	localparam logic [1:0] COMP_FRAGMENT = 2'd3;

	localparam int HOLD_CYCLES   = 80;
	localparam int SETTLE_CYCLES = 8;

	// predicts the converted bytes and checks them in order
	class codec_scoreboard;
		logic       dir;
		logic [1:0] comp;
		held_t      held;
		logic [7:0] held_dig;
		logic [7:0] step_bytes[$];
		upc_out_t   expected_bytes[$];
		int         errors;

		function new();
			dir = DIR_ENCODE;
			comp = COMPONENT_RESET;
			held = HELD_NONE;
			held_dig = 8'h00;
			errors = 0;
		endfunction

		// which components let a byte pass unescaped, one bit per component
		function logic [3:0] class_bits(input logic [7:0] c);
			if (c == 8'h2f || c == 8'h40) return 4'he;
			if (c == 8'h3f) return 4'hc;
			// backslash passes as the table has it
			if (c == 8'h21 || c == 8'h24 || c == 8'h3d || c == 8'h5c || c == 8'h5f || c == 8'h7e)
				return 4'hf;
			if ((c >= 8'h26 && c <= 8'h2e) || (c >= 8'h30 && c <= 8'h3b) ||
			    (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a))
				return 4'hf;
			return 4'h0;
		endfunction

		// lower-case ascii digit of a nibble
		function logic [7:0] hex_ascii(input logic [3:0] nib);
			if (nib < 4'd10) return {4'h0, nib} + 8'h30;
			return {4'h0, nib} + 8'h57; // 'a' - 10
		endfunction

		// {valid, value} of a hex digit in either case
		function logic [4:0] digit_value(input logic [7:0] c);
			logic [7:0] v;
			v = 8'hff;
			if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
			else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h37;
			else if (c >= 8'h61 && c <= 8'h66) v = c - 8'h57;
			if (v == 8'hff) return 5'd0;
			return {1'b1, v[3:0]};
		endfunction

		// byte seen with nothing held
		function void take_fresh(input logic [7:0] c, input logic fin);
			if (c == PCT_CHAR && !fin) held = HELD_PCT;
			else step_bytes.push_back(c);
		endfunction

		function void write_reg(input logic idx, input logic [1:0] val);
			if (idx == CFG_DIRECTION) begin
				dir = val[0];
				held = HELD_NONE;
				held_dig = 8'h00;
			end else begin
				comp = val;
			end
		endfunction

		// expected output bytes of one accepted input item
		function void note_byte_in(input upc_in_t it);
			logic [7:0] c;
			logic       fin;
			logic [3:0] cb;
			logic [4:0] lo;
			logic [4:0] hi;
			upc_out_t   o;
			c = it.in_char;
			fin = it.in_last;
			cb = class_bits(c);
			step_bytes.delete();
			if (dir == DIR_ENCODE) begin
				if (c < 8'h80 && cb[comp]) begin
					step_bytes.push_back(c);
				end else begin
					step_bytes.push_back(PCT_CHAR);
					step_bytes.push_back(hex_ascii(c[7:4]));
					step_bytes.push_back(hex_ascii(c[3:0]));
				end
			end else begin
				case (held)
					HELD_NONE: begin
						take_fresh(c, fin);
					end
					HELD_PCT: begin
						lo = digit_value(c);
						if (lo[4] && !fin) begin
							held_dig = c;
							held = HELD_DIGIT;
						end else begin
							held = HELD_NONE;
							step_bytes.push_back(PCT_CHAR);
							take_fresh(c, fin);
						end
					end
					default: begin
						lo = digit_value(c);
						hi = digit_value(held_dig);
						held = HELD_NONE;
						if (lo[4] && hi[4]) begin
							step_bytes.push_back({hi[3:0], lo[3:0]});
						end else begin
							// broken escape goes out literally, the new byte is looked at again
							step_bytes.push_back(PCT_CHAR);
							step_bytes.push_back(held_dig);
							take_fresh(c, fin);
						end
						held_dig = 8'h00;
					end
				endcase
			end
			if (fin) begin
				held = HELD_NONE;
				held_dig = 8'h00;
			end
			foreach (step_bytes[i]) begin
				o.out_char = step_bytes[i];
				o.out_last = fin && (i == step_bytes.size() - 1);
				expected_bytes.push_back(o);
			end
		endfunction

		// compare one output item with the oldest expectation
		function void check_byte_out(input upc_out_t got);
			upc_out_t exp_b;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output item char %h last %b", $time,
				         got.out_char, got.out_last);
				errors++;
				return;
			end
			exp_b = expected_bytes.pop_front();
			if (got.out_char !== exp_b.out_char) begin
				$display("%0t: out_char expected %h actual %h", $time, exp_b.out_char,
				         got.out_char);
				errors++;
			end
			if (got.out_last !== exp_b.out_last) begin
				$display("%0t: out_last expected %b actual %b", $time, exp_b.out_last,
				         got.out_last);
				errors++;
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [1:0] cfg_data = 2'd0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	upc_in_t    in_data = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	upc_out_t   out_data;

	codec_scoreboard sb = new();

	logic       idle_en = 1'b1;
	int         hold_req = 0;
	int         hold_seen = 0;
	int         items_sent = 0;
	logic [7:0] str_buf[$];

	uri_percent_codec_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#1200000;
		$display("FAIL uri_percent_codec_unit");
		$finish;
	end

	// output side: check accepted items, then pick next ready
	initial begin : rx_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) sb.check_byte_out(out_data);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (idle_en) begin
				out_ready <= ($urandom_range(99) >= 33);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// random byte, biased to printable ascii, sometimes nul
	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(99);
		if (r < 5) return 8'h00;
		if (r < 55) return 8'($urandom_range(8'h7e, 8'h20));
		return 8'($urandom_range(255, 1));
	endfunction

	// random hex digit in either case
	function automatic logic [7:0] rand_hex();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'(8'h30 + v);
		if ($urandom_range(1) == 1) return 8'(8'h37 + v);
		return 8'(8'h57 + v);
	endfunction

	// offer one input item and wait for it to be taken
	task automatic send_byte(input logic [7:0] c, input logic fin);
		upc_in_t it;
		it.in_char = c;
		it.in_last = fin;
		while (idle_en && $urandom_range(99) < 33) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		sb.note_byte_in(it);
		items_sent++;
	endtask

	task automatic send_text(input string s, input logic fin);
		for (int i = 0; i < s.len(); i++) send_byte(s[i], fin && (i == s.len() - 1));
	endtask

	// stop sending and let every expected item come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic idx, input logic [1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// random strings under one setting; optional long output stall part way in
	task automatic run_phase(input logic d, input logic [1:0] c, input int n, input bit stall);
		int  first;
		int  r;
		bit  stalled;
		wait_drained();
		cfg_write(CFG_COMPONENT, c);
		// upper data bit is don't-care for direction
		cfg_write(CFG_DIRECTION, {1'($urandom_range(1)), d});
		first = items_sent;
		stalled = 1'b0;
		while (items_sent - first < n) begin
			str_buf.delete();
			if (d == DIR_ENCODE) begin
				repeat ($urandom_range(6, 1)) str_buf.push_back(rand_byte());
			end else begin
				repeat ($urandom_range(4, 1)) begin
					r = $urandom_range(99);
					if (r < 55) begin
						str_buf.push_back(PCT_CHAR);
						str_buf.push_back(rand_hex());
						str_buf.push_back(rand_hex());
					end else if (r < 65) begin
						str_buf.push_back(PCT_CHAR);
						str_buf.push_back(rand_byte());
					end else if (r < 72) begin
						str_buf.push_back(PCT_CHAR);
						str_buf.push_back(rand_hex());
						str_buf.push_back(rand_byte());
					end else if (r < 76) begin
						str_buf.push_back(PCT_CHAR);
					end else begin
						str_buf.push_back(rand_byte());
					end
				end
			end
			if (stall && !stalled && items_sent - first >= 6) begin
				hold_req <= hold_req + 1;
				stalled = 1'b1;
			end
			foreach (str_buf[i]) send_byte(str_buf[i], i == str_buf.size() - 1);
		end
	endtask

	// main sequence
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// encode extremes under reset settings (path)
		send_byte(8'h01, 1'b0);
		send_byte(8'hff, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h7f, 1'b0);
		send_byte(8'h5c, 1'b0);
		send_byte(8'h3f, 1'b0);
		send_byte(8'h00, 1'b1);
		wait_drained();
		cfg_write(CFG_COMPONENT, COMP_USERINFO);
		send_text("/@", 1'b1);
		wait_drained();

		// decode: good escapes, decoded zero, broken and truncated escapes
		cfg_write(CFG_DIRECTION, {1'b0, DIR_DECODE});
		send_text("%4a", 1'b1);
		send_text("%00", 1'b1);
		send_text("%g", 1'b1);
		send_text("%4z", 1'b1);
		send_text("%", 1'b1);
		send_text("%4", 1'b1);
		send_text("%%4F", 1'b1);
		// direction write drops a held escape
		send_text("%4", 1'b0);
		wait_drained();
		cfg_write(CFG_DIRECTION, {1'b1, DIR_DECODE});
		send_text("1", 1'b1);

		// random part across settings
		run_phase(DIR_ENCODE, COMP_FRAGMENT, 20, 1'b0);
		run_phase(DIR_DECODE, COMP_QUERY, 20, 1'b0);
		idle_en <= 1'b0;
		run_phase(DIR_ENCODE, COMP_QUERY, 20, 1'b1);
		run_phase(DIR_DECODE, COMP_PATH, 20, 1'b0);
		wait_drained();
		idle_en <= 1'b1;
		run_phase(DIR_ENCODE, COMP_USERINFO, 20, 1'b0);
		run_phase(DIR_DECODE, COMP_FRAGMENT, 20, 1'b0);
		run_phase(DIR_ENCODE, COMP_PATH, 20, 1'b0);
		run_phase(DIR_DECODE, COMP_USERINFO, 20, 1'b0);
		wait_drained();

		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("PASS uri_percent_codec_unit");
		end else begin
			$display("FAIL uri_percent_codec_unit");
		end
		$finish;
	end

endmodule
